@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
  localparam logic [2:0] ERR_EOF_STRING = 3'd1;
  localparam logic [2:0] ERR_EOF_ESCAPE = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd4;

  // Command queue between the parser and the emitter.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Main action of one command.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CP,
    ACT_BYTE,
    ACT_CLOSE,
    ACT_ERR
  } act_t;

  // One command describes every beat that one input byte causes: an optional
  // three-byte release of a held high surrogate, then the main action.
  typedef struct packed {
    logic        rel;
    logic [9:0]  hb;
    act_t        act;
    logic [20:0] cp;
    logic [2:0]  err;
  } cmd_t;

  // Number of UTF-8 bytes for a code point.
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp >= 21'h10000) begin
      len = 3'd4;
    end else if (cp >= 21'h800) begin
      len = 3'd3;
    end else if (cp >= 21'h80) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Byte at position pos of the UTF-8 form of cp.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] pos);
    logic [2:0] len;
    logic [7:0] b;
    len = utf8_len(cp);
    b = 8'h00;
    unique case (len)
      3'd4: begin
        unique case (pos)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        unique case (pos)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd2: begin
        if (pos == 2'd0) begin
          b = {3'b110, cp[10:6]};
        end else begin
          b = {2'b10, cp[5:0]};
        end
      end
      default: b = {1'b0, cp[6:0]};
    endcase
    return b;
  endfunction

endpackage

@@ rtl/jsu_front.sv @@
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            fifo_full,
  output logic            in_ready,
  output logic            push,
  output jsu_pkg::cmd_t   push_cmd
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_STR   = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_HEX   = 3'd3;
  localparam logic [2:0] PH_LOWBS = 3'd4;
  localparam logic [2:0] PH_LOWU  = 3'd5;
  // Internal dispatch code only, never stored.
  localparam logic [2:0] MODE_DONE = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_NUL   = 8'h00;

  logic [2:0]  phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        hp_r, hp_nxt;
  logic [9:0]  hb_r, hb_nxt;

  logic [2:0]  mode;
  logic        is_hex;
  logic [3:0]  digit;
  logic [15:0] v;
  logic        accept;
  cmd_t        cmd;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_hex = 1'b0;
    digit  = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      is_hex = 1'b1;
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      is_hex = 1'b1;
      digit  = in_byte[3:0] + 4'd9;
    end
  end

  assign v = {acc_r, digit};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hp_nxt    = hp_r;
    hb_nxt    = hb_r;
    cmd       = '0;
    cmd.act   = ACT_NONE;
    cmd.hb    = hb_r;
    mode      = phase_r;

    // After a held high surrogate, anything but a following \u hands the
    // byte on as ordinary string or escape text, with the surrogate released.
    if (phase_r == PH_LOWBS) begin
      if (in_byte == CH_BSL) begin
        phase_nxt = PH_LOWU;
        mode      = MODE_DONE;
      end else begin
        cmd.rel = 1'b1;
        hp_nxt  = 1'b0;
        hb_nxt  = '0;
        mode    = PH_STR;
      end
    end else if (phase_r == PH_LOWU) begin
      if (in_byte == CH_U) begin
        phase_nxt = PH_HEX;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        mode      = MODE_DONE;
      end else begin
        cmd.rel = 1'b1;
        hp_nxt  = 1'b0;
        hb_nxt  = '0;
        mode    = PH_ESC;
      end
    end

    unique case (mode)
      PH_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          phase_nxt = PH_STR;
        end else if (!(in_byte == CH_SPACE || (in_byte >= 8'h09 && in_byte <= 8'h0d))) begin
          cmd.act = ACT_ERR;
          cmd.err = ERR_NO_QUOTE;
        end
      end
      PH_STR: begin
        if (in_byte == CH_QUOTE) begin
          cmd.act   = ACT_CLOSE;
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          hp_nxt    = 1'b0;
          hb_nxt    = '0;
        end else if (in_byte == CH_NUL) begin
          cmd.act   = ACT_ERR;
          cmd.err   = ERR_EOF_STRING;
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          hp_nxt    = 1'b0;
          hb_nxt    = '0;
        end else if (in_byte == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else begin
          cmd.act   = ACT_BYTE;
          cmd.cp    = {13'd0, in_byte};
          phase_nxt = PH_STR;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_STR;
        cmd.act   = ACT_BYTE;
        unique case (in_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: cmd.cp = {13'd0, in_byte};
          CH_B: cmd.cp = 21'h08;
          CH_F: cmd.cp = 21'h0c;
          CH_N: cmd.cp = 21'h0a;
          CH_R: cmd.cp = 21'h0d;
          CH_T: cmd.cp = 21'h09;
          CH_U: begin
            cmd.act   = ACT_NONE;
            phase_nxt = PH_HEX;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
          default: begin
            cmd.act   = ACT_ERR;
            cmd.err   = (in_byte == CH_NUL) ? ERR_EOF_ESCAPE : ERR_BAD_ESCAPE;
            phase_nxt = PH_IDLE;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            hp_nxt    = 1'b0;
            hb_nxt    = '0;
          end
        endcase
      end
      PH_HEX: begin
        if (!is_hex) begin
          cmd.rel   = hp_r;
          cmd.act   = ACT_ERR;
          cmd.err   = ERR_BAD_HEX;
          phase_nxt = PH_IDLE;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          hp_nxt    = 1'b0;
          hb_nxt    = '0;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = v[11:0];
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (hp_r && v[15:10] == 6'b110111) begin
            // Surrogate pair: one supplementary code point.
            cmd.act   = ACT_CP;
            cmd.cp    = {1'b0, hb_r, v[9:0]} + 21'h10000;
            hp_nxt    = 1'b0;
            hb_nxt    = '0;
            phase_nxt = PH_STR;
          end else begin
            cmd.rel = hp_r;
            if (v[15:10] == 6'b110110) begin
              hp_nxt    = 1'b1;
              hb_nxt    = v[9:0];
              phase_nxt = PH_LOWBS;
            end else begin
              hp_nxt    = 1'b0;
              hb_nxt    = '0;
              cmd.act   = ACT_CP;
              cmd.cp    = {5'd0, v};
              phase_nxt = PH_STR;
            end
          end
        end
      end
      MODE_DONE: begin
      end
      default: begin
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        hp_nxt    = 1'b0;
        hb_nxt    = '0;
      end
    endcase
  end

  assign push     = accept && (cmd.rel || cmd.act != ACT_NONE);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      hp_r    <= 1'b0;
      hb_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hp_r    <= hp_nxt;
      hb_r    <= hb_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hp_r |-> (phase_r == PH_LOWBS || phase_r == PH_LOWU || phase_r == PH_HEX))
    else $error("high surrogate held outside the pairing phases");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (!hp_r && cnt_r == 2'd0 && acc_r == 12'd0))
    else $error("idle phase with leftover escape state");
`endif

endmodule

@@ rtl/jsu_cmd_fifo.sv @@
module jsu_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head_cmd
);
  import jsu_pkg::*;

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_data_byte,
  output logic [2:0]    out_error_code,
  output logic          out_last
);
  import jsu_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        ov_r;
  logic [1:0]  kind_r;
  logic [7:0]  data_r;
  logic [2:0]  err_r;
  logic        last_r;

  logic [20:0] rel_cp;
  logic [2:0]  n_rel, n_main, n_beats;
  logic [2:0]  m_idx;
  logic        in_rel;
  logic        adv, beat_last;
  logic [1:0]  b_kind;
  logic [7:0]  b_data;
  logic [2:0]  b_err;

  assign rel_cp = {5'd0, 6'b110110, head_cmd.hb};
  assign n_rel  = head_cmd.rel ? 3'd3 : 3'd0;

  always_comb begin
    unique case (head_cmd.act)
      ACT_NONE: n_main = 3'd0;
      ACT_CP:   n_main = utf8_len(head_cmd.cp);
      default:  n_main = 3'd1;
    endcase
  end

  assign n_beats   = n_rel + n_main;
  assign in_rel    = head_cmd.rel && (idx_r < 3'd3);
  assign m_idx     = idx_r - n_rel;
  assign beat_last = (idx_r == n_beats - 3'd1);
  assign adv       = head_valid && (!ov_r || out_ready);
  assign pop       = adv && beat_last;

  always_comb begin
    b_kind = KIND_DATA;
    b_data = 8'h00;
    b_err  = 3'd0;
    if (in_rel) begin
      b_data = utf8_byte(rel_cp, idx_r[1:0]);
    end else begin
      unique case (head_cmd.act)
        ACT_CP:    b_data = utf8_byte(head_cmd.cp, m_idx[1:0]);
        ACT_BYTE:  b_data = head_cmd.cp[7:0];
        ACT_CLOSE: b_kind = KIND_CLOSE;
        ACT_ERR: begin
          b_kind = KIND_ERROR;
          b_err  = head_cmd.err;
        end
        default: b_data = 8'h00;
      endcase
    end
  end

  assign idx_nxt = pop ? 3'd0 : (adv ? idx_r + 3'd1 : idx_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= b_kind;
      data_r <= b_data;
      err_r  <= b_err;
      last_r <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < n_beats))
    else $error("beat index beyond the command length");
  a_idx_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 3'd0) |-> head_valid)
    else $error("beat index running without a command");
`endif

endmodule

@@ rtl/json_string_unescape_utf8_unit.sv @@
// Path: an accepted byte becomes a command in the command queue, and the back end then
// registers its result beats in the output register, one per cycle while out_ready is high.
// Throughput: one input byte per cycle while each byte yields at most one beat and out_ready
// is high; the single output register limits the rate to one result beat per cycle overall.
// Reset: synchronous, active-low rst_n empties the queue and output and returns
// the parser to idle, waiting for an opening quote.
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  // The front end parses one byte per cycle while the queue has room and turns every
  // byte that has visible effect into a single command. Whitespace, quotes that open a
  // string, backslashes and hex digits still being gathered produce none.
  logic push, fifo_full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .fifo_full (fifo_full),
    .in_ready  (in_ready),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // A short command queue decouples parsing from the multi-beat UTF-8
  // expansion, so plain text keeps flowing while a long code point drains.
  jsu_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // The back end walks each command beat by beat: first the three bytes of
  // a released high surrogate if any, then the main action, marking the
  // final beat with out_last. Its output register acts as the skid stage.
  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

@@ dv/json_string_unescape_utf8_unit_tb.sv @@
// Testbench for the JSON string unescaper with UTF-8 output.
//
// Every byte that the block accepts is fed, at the same clock edge, to a
// predictor of the unescaper that is kept in this file. The predictor adds
// the beats that the byte should cause to a queue of expected beats, and
// every result beat that the block hands over is compared field by field
// with the oldest entry of that queue.
//
// The stimulus starts with a few short directed sequences: whitespace and
// stray bytes before the opening quote, extreme bytes and code points, an
// unpaired high surrogate with a lone low one, and each way of leaving a
// string on an error. It then runs a long stretch of random strings. These
// are mostly well formed with random content, and are laced with broken
// escapes, interrupted surrogates and stray bytes between strings.
module json_string_unescape_utf8_unit_tb;
  import jsu_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BYTES = 180;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 100;

  // Bytes with a meaning of their own in JSON text.
  localparam logic [7:0] CH_EOF    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  // The error field of a beat that is not an error.
  localparam logic [2:0] NO_CODE = 3'd0;

  // Where the unescaper stands between two input bytes.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_HEX,
    SCAN_WANT_BSLASH,
    SCAN_WANT_U
  } scan_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       last;
  } beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [2:0] out_error_code;
  logic       out_last;

  json_string_unescape_utf8_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  // Predictor state, a copy of what the block keeps.
  scan_t       scan_phase;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic        high_held;
  logic [9:0]  high_part;

  // Beats caused by the byte being predicted, and beats still owed by the block.
  beat_t byte_beats[$];
  beat_t expected_utf8_beats[$];

  // Idling controls, set by the test tasks.
  bit tx_gaps;
  bit rx_stalls;
  bit hold_request;
  int burst_left;

  int fail_count  = 0;
  int cycle_count = 0;
  int bytes_sent  = 0;
  int data_beats  = 0;
  int close_beats = 0;
  int error_beats = 0;

  beat_t got_beat;
  beat_t want_beat;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the unescaper.
  // ---------------------------------------------------------------------------

  function automatic void add_beat(input logic [1:0] kind, input logic [7:0] data,
                                   input logic [2:0] code);
    beat_t b;
    b.kind       = kind;
    b.data_byte  = data;
    b.error_code = code;
    b.last       = 1'b0;
    byte_beats.insert(byte_beats.size(), b);
  endfunction

  function automatic void clear_scan();
    scan_phase = SCAN_IDLE;
    hex_acc    = '0;
    hex_cnt    = '0;
    high_held  = 1'b0;
    high_part  = '0;
  endfunction

  // An error beat always sends the block back to waiting for a quote.
  function automatic void raise_error(input logic [2:0] code);
    add_beat(KIND_ERROR, 8'h00, code);
    clear_scan();
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Bit 4 says whether the byte is a hex digit at all; bits 3..0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= "A" && c <= "F") begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end else if (c >= "a" && c <= "f") begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp >= 21'h10000) begin
      add_beat(KIND_DATA, {5'b11110, cp[20:18]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[17:12]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[11:6]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
    end else if (cp >= 21'h800) begin
      add_beat(KIND_DATA, {4'b1110, cp[15:12]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[11:6]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
    end else if (cp >= 21'h80) begin
      add_beat(KIND_DATA, {3'b110, cp[10:6]}, NO_CODE);
      add_beat(KIND_DATA, {2'b10, cp[5:0]}, NO_CODE);
    end else begin
      add_beat(KIND_DATA, {1'b0, cp[6:0]}, NO_CODE);
    end
  endfunction

  // A high surrogate that found no partner goes out as a three-byte form.
  function automatic void release_held_high();
    if (high_held) begin
      emit_code_point({5'd0, 6'b110110, high_part});
      high_held = 1'b0;
      high_part = '0;
    end
  endfunction

  function automatic void text_byte(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      add_beat(KIND_CLOSE, 8'h00, NO_CODE);
      clear_scan();
    end else if (c == CH_EOF) begin
      raise_error(ERR_EOF_STRING);
    end else if (c == CH_BSLASH) begin
      scan_phase = SCAN_ESCAPE;
    end else begin
      add_beat(KIND_DATA, c, NO_CODE);
      scan_phase = SCAN_TEXT;
    end
  endfunction

  function automatic void escape_byte(input logic [7:0] c);
    logic [7:0] value;
    logic       emit;
    value      = c;
    emit       = 1'b1;
    scan_phase = SCAN_TEXT;
    case (c)
      CH_EOF: begin
        emit = 1'b0;
        raise_error(ERR_EOF_ESCAPE);
      end
      CH_QUOTE, CH_BSLASH, CH_SLASH: value = c;
      "b": value = 8'h08;
      "f": value = 8'h0c;
      "n": value = 8'h0a;
      "r": value = 8'h0d;
      "t": value = 8'h09;
      CH_U: begin
        emit       = 1'b0;
        scan_phase = SCAN_HEX;
        hex_acc    = '0;
        hex_cnt    = '0;
      end
      default: begin
        emit = 1'b0;
        raise_error(ERR_BAD_ESCAPE);
      end
    endcase
    if (emit) add_beat(KIND_DATA, value, NO_CODE);
  endfunction

  // A complete \u value with no high surrogate waiting for it.
  function automatic void start_code_unit(input logic [15:0] unit);
    if (unit >= 16'hd800 && unit <= 16'hdbff) begin
      high_held  = 1'b1;
      high_part  = unit[9:0];
      scan_phase = SCAN_WANT_BSLASH;
    end else begin
      emit_code_point({5'b0, unit});
      scan_phase = SCAN_TEXT;
    end
  endfunction

  function automatic void hex_byte(input logic [7:0] c);
    logic [4:0]  digit;
    logic [15:0] unit;
    logic [20:0] cp;
    digit = hex_value(c);
    if (!digit[4]) begin
      release_held_high();
      raise_error(ERR_BAD_HEX);
    end else begin
      hex_acc = {hex_acc[11:0], digit[3:0]};
      if (hex_cnt != 2'd3) begin
        hex_cnt = hex_cnt + 2'd1;
      end else begin
        unit    = hex_acc;
        hex_acc = '0;
        hex_cnt = '0;
        if (high_held && unit >= 16'hdc00 && unit <= 16'hdfff) begin
          cp = {1'b0, high_part, unit[9:0]} + 21'h10000;
          emit_code_point(cp);
          high_held  = 1'b0;
          high_part  = '0;
          scan_phase = SCAN_TEXT;
        end else begin
          release_held_high();
          start_code_unit(unit);
        end
      end
    end
  endfunction

  // Works out every beat that one accepted byte causes and queues them in order.
  function automatic void predict_unescape(input logic [7:0] c);
    byte_beats.delete();
    case (scan_phase)
      SCAN_IDLE: begin
        if (c == CH_QUOTE) begin
          scan_phase = SCAN_TEXT;
        end else if (!is_blank(c)) begin
          raise_error(ERR_NO_QUOTE);
        end
      end
      SCAN_TEXT:   text_byte(c);
      SCAN_ESCAPE: escape_byte(c);
      SCAN_HEX:    hex_byte(c);
      SCAN_WANT_BSLASH: begin
        if (c == CH_BSLASH) begin
          scan_phase = SCAN_WANT_U;
        end else begin
          release_held_high();
          text_byte(c);
        end
      end
      SCAN_WANT_U: begin
        if (c == CH_U) begin
          scan_phase = SCAN_HEX;
          hex_acc    = '0;
          hex_cnt    = '0;
        end else begin
          release_held_high();
          escape_byte(c);
        end
      end
      default: clear_scan();
    endcase
    if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].last = 1'b1;
    foreach (byte_beats[i]) expected_utf8_beats.insert(expected_utf8_beats.size(), byte_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors and checking.
  // ---------------------------------------------------------------------------

  // Every accepted byte goes to the predictor at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_unescape(in_byte);
  end

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    end
  endfunction

  // Each beat that the block hands over is held against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_beat = {out_kind, out_data_byte, out_error_code, out_last};
      case (out_kind)
        KIND_DATA:  data_beats++;
        KIND_CLOSE: close_beats++;
        default:    error_beats++;
      endcase
      if (expected_utf8_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: beat with nothing expected, got kind %0d data 0x%0h code %0d last %0b",
                   $time, out_kind, out_data_byte, out_error_code, out_last);
        end
      end else begin
        want_beat = expected_utf8_beats.pop_front();
        compare_field("kind", 8'(want_beat.kind), 8'(got_beat.kind));
        compare_field("data_byte", want_beat.data_byte, got_beat.data_byte);
        compare_field("error_code", 8'(want_beat.error_code), 8'(got_beat.error_code));
        compare_field("last", 8'(want_beat.last), 8'(got_beat.last));
      end
    end
  end

  // Watchdog against a block that hangs or stops handing over beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats still expected.",
               cycle_count, expected_utf8_beats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver. It either takes every beat, or stalls in short random runs,
  // or, when asked, holds off for a long stretch that it counts itself so that
  // the block's queue fills and it has to stall its input.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending bytes.
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the falling edge after it has been taken.
  // It is entered at a falling edge, so valid is only ever raised or lowered
  // once per time step. With gaps enabled the bytes go out in bursts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stops offering bytes until every beat owed has been handed over.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_utf8_beats.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    if ($urandom_range(0, 1) == 1) return 8'h37 + {4'h0, n};
    return 8'h57 + {4'h0, n};
  endfunction

  task automatic send_u_escape(input logic [15:0] unit);
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(unit[i * 4 +: 4]));
  endtask

  function automatic logic [7:0] simple_escape_letter(input int idx);
    case (idx)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] c);
    return c == CH_EOF || c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_U
        || c == "b" || c == "f" || c == "n" || c == "r" || c == "t";
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] random_bad_letter();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
    return b;
  endfunction

  // Includes the end-of-input byte, which is also a bad hex digit.
  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    logic [4:0] d;
    do begin
      b = 8'($urandom_range(0, 255));
      d = hex_value(b);
    end while (d[4]);
    return b;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return 8'h09;
      2:       return 8'h0a;
      3:       return 8'h0b;
      4:       return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] random_stray();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_blank(b) || b == CH_QUOTE);
    return b;
  endfunction

  // A random UTF-16 unit from one of several ranges, the range edges among them.
  function automatic logic [15:0] pick_code_unit(input int cls);
    case (cls)
      0: return 16'($urandom_range(16'h0000, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hffff));
      3: return 16'($urandom_range(16'hd800, 16'hdbff));
      4: return 16'($urandom_range(16'hdc00, 16'hdfff));
      default: begin
        case ($urandom_range(0, 7))
          0:       return 16'h0000;
          1:       return 16'h007f;
          2:       return 16'h0080;
          3:       return 16'h07ff;
          4:       return 16'h0800;
          5:       return 16'hd7ff;
          6:       return 16'he000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  // A \u escape cut short by a byte that is no hex digit, after k digits.
  task automatic send_bad_hex_tail(input int k);
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    repeat (k) send_byte(hex_char(4'($urandom_range(0, 15))));
    send_byte(random_non_hex());
  endtask

  task automatic send_surrogate_pair();
    send_u_escape(pick_code_unit(3));
    send_u_escape(pick_code_unit(4));
  endtask

  // A high surrogate followed by a plain byte, a string end, an escape or another \u escape.
  task automatic send_interrupted_high(output bit ended);
    ended = 1'b0;
    send_u_escape(pick_code_unit(3));
    case ($urandom_range(0, 8))
      0: send_byte(random_plain());
      1: begin
        send_byte(CH_QUOTE);
        ended = 1'b1;
      end
      2: begin
        send_byte(CH_EOF);
        ended = 1'b1;
      end
      3: begin
        send_byte(CH_BSLASH);
        send_byte(simple_escape_letter($urandom_range(0, 7)));
      end
      4: begin
        send_byte(CH_BSLASH);
        send_byte(CH_EOF);
        ended = 1'b1;
      end
      5: begin
        send_byte(CH_BSLASH);
        send_byte(random_bad_letter());
        ended = 1'b1;
      end
      6: begin
        send_bad_hex_tail($urandom_range(0, 3));
        ended = 1'b1;
      end
      7: send_u_escape(pick_code_unit($urandom_range(0, 2)));
      default: send_u_escape(pick_code_unit(3));
    endcase
  endtask

  task automatic send_token(output bit ended);
    ended = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2: send_byte(random_plain());
      3, 4: begin
        send_byte(CH_BSLASH);
        send_byte(simple_escape_letter($urandom_range(0, 7)));
      end
      5, 6: send_u_escape(pick_code_unit($urandom_range(0, 5)));
      7, 8: send_surrogate_pair();
      default: send_interrupted_high(ended);
    endcase
  endtask

  // Mostly a clean close, sometimes one of the error exits.
  task automatic send_string_end();
    case ($urandom_range(0, 10))
      7: send_byte(CH_EOF);
      8: begin
        send_byte(CH_BSLASH);
        send_byte(CH_EOF);
      end
      9: begin
        send_byte(CH_BSLASH);
        send_byte(random_bad_letter());
      end
      10: send_bad_hex_tail($urandom_range(0, 3));
      default: send_byte(CH_QUOTE);
    endcase
  endtask

  task automatic send_random_string(input int max_tokens);
    int  n;
    bit  ended;
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) send_byte(random_stray());
      else send_byte(random_blank());
    end
    send_byte(CH_QUOTE);
    ended = 1'b0;
    n     = $urandom_range(1, max_tokens);
    for (int i = 0; i < n && !ended; i++) send_token(ended);
    if (!ended) send_string_end();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Whitespace is skipped silently; anything else but a quote is an error.
  task automatic test_idle_skipping();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_byte(CH_SPACE);
    send_byte(8'h09);
    send_byte(8'h0d);
    send_byte(CH_EOF);
    send_byte(8'hff);
    wait_for_results();
  endtask

  // The lowest and highest raw bytes, an escape, and the code point extremes.
  task automatic test_string_extremes();
    send_byte(CH_QUOTE);
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(CH_BSLASH);
    send_byte("t");
    send_u_escape(16'h0000);
    send_u_escape(16'hdbff);
    send_u_escape(16'hdfff);
    send_byte(CH_QUOTE);
    wait_for_results();
  endtask

  // A high surrogate broken off by a plain byte, then a lone low surrogate,
  // then a bad escape letter that ends the string.
  task automatic test_surrogate_recovery();
    send_byte(CH_QUOTE);
    send_u_escape(16'hd800);
    send_byte("x");
    send_u_escape(16'hdc00);
    send_byte(CH_BSLASH);
    send_byte("q");
    wait_for_results();
  endtask

  // End of input in text and in an escape, and a bad hex digit.
  task automatic test_error_exits();
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_EOF);
    send_byte(CH_QUOTE);
    send_byte(CH_EOF);
    send_byte(CH_QUOTE);
    send_bad_hex_tail(2);
    wait_for_results();
  endtask

  // Bytes on every cycle that the block is ready, with the receiver always ready.
  task automatic test_back_to_back();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    repeat (3) send_random_string(6);
    wait_for_results();
  endtask

  // Four-byte characters pile up while the receiver holds off, so that the
  // block's queue fills and the input is stalled for a long stretch.
  task automatic test_output_holdoff();
    tx_gaps      = 1'b0;
    rx_stalls    = 1'b0;
    hold_request = 1'b1;
    send_byte(CH_QUOTE);
    repeat (6) send_surrogate_pair();
    send_byte(CH_QUOTE);
    wait_for_results();
    while (hold_request) @(negedge clk);
  endtask

  // The bulk of the run: random strings under changing idling patterns, with
  // an occasional pause until the block has handed everything over.
  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      send_random_string(10);
      if ($urandom_range(0, 12) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    tx_gaps      = 1'b0;
    rx_stalls    = 1'b0;
    hold_request = 1'b0;
    burst_left   = 0;
    clear_scan();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_skipping();
    test_string_extremes();
    test_surrogate_recovery();
    test_error_exits();
    test_back_to_back();
    test_output_holdoff();
    test_random_traffic();

    // Let any stray beat surface before the verdict.
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes with bursts, stalls and a long hold-off; checked %0d beats:",
             bytes_sent, data_beats + close_beats + error_beats);
    $display("%0d data bytes, %0d string ends, %0d errors.", data_beats, close_beats,
             error_beats);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
